### hw/rtl/scs_pkg.sv
// Shared types, codes and reset values for the moving-average crossover signal block.
// No dependencies; the channel interfaces and the signal core depend on this package.
package scs_pkg;

	localparam int MAX_WINDOW_DEF = 255;
	localparam int PRICE_BITS_DEF = 32;

	localparam int WIN_W      = 8;
	localparam int QTY_W      = 16;
	localparam int CLOSE_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIN_W-1:0] FAST_WINDOW_RST = 8'd10;
	localparam logic [WIN_W-1:0] SLOW_WINDOW_RST = 8'd30;
	localparam logic [QTY_W-1:0] ORDER_QTY_RST   = 16'd100;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAST_WINDOW = 2'd0,
		REG_SLOW_WINDOW = 2'd1,
		REG_ORDER_QTY   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMP_LT = 2'd0,
		CMP_EQ = 2'd1,
		CMP_GT = 2'd2
	} cmp_t;

	typedef struct packed {
		logic [CLOSE_W-1:0] close_price;
		logic [QTY_W-1:0]   position_qty;
	} bar_t;

	typedef struct packed {
		action_t            action;
		logic [QTY_W-1:0]   quantity;
		logic               warmed_up;
	} signal_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

### hw/rtl/scs_bar_if.sv
// Valid/ready channel that carries one bar (closing price and position) per transfer.
// Depends on scs_pkg for the payload type.
interface scs_bar_if;
	logic          valid;
	logic          ready;
	scs_pkg::bar_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/scs_signal_if.sv
// Valid/ready channel that carries one trade signal per transfer.
// Depends on scs_pkg for the payload type.
interface scs_signal_if;
	logic             valid;
	logic             ready;
	scs_pkg::signal_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/scs_cfg_if.sv
// Register write channel: valid/ready with a register index and write data.
// Depends on scs_pkg for the payload type.
interface scs_cfg_if;
	logic             valid;
	logic             ready;
	scs_pkg::cfg_wr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/scs_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module scs_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### hw/rtl/sma_crossover_signal_core.sv
// Moving-average crossover signal core: takes one bar per transfer and returns one signal per
// bar. It sustains one bar per clock while the output does not stall: the price RAM writes
// the new price and reads both outgoing prices (fast and slow window) in the same cycle, and the
// running sums, the window products and the crossover decision each take one pipeline stage.
// The pipeline moves as a whole and halts only while a finished signal waits on the output.
// Writing either window register restarts the history; signals carry no action, warmed_up low,
// until the stored prices outnumber the larger window. Depends on scs_pkg, the channel interfaces and scs_ram.
module sma_crossover_signal_core #(
	parameter int MAX_WINDOW = scs_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = scs_pkg::PRICE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	scs_cfg_if.sink      cfg,
	scs_bar_if.sink      bar,
	scs_signal_if.source sig
);
	import scs_pkg::*;

	localparam int DEPTH  = MAX_WINDOW + 1;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int AW     = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
	localparam int SUM_W  = PRICE_BITS + WIN_W;
	localparam int PROD_W = SUM_W + WIN_W;
	localparam int CNT_W  = WIN_W + 1;
	localparam logic [AW-1:0]    MAX_WIN_A = AW'(MAX_WINDOW);
	localparam logic [AW-1:0]    DEPTH_A   = AW'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [AW-1:0] wa;
		wa = AW'(w);
		if (w == '0) begin
			return WIN_W'(1);
		end else if (wa > MAX_WIN_A) begin
			return WIN_W'(MAX_WIN_A);
		end
		return w;
	endfunction

	function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] wp,
			input logic [WIN_W-1:0] k);
		logic [AW-1:0] wpa;
		logic [AW-1:0] ka;
		logic [AW-1:0] r;
		wpa = AW'(wp);
		ka  = AW'(k);
		if (wpa >= ka) begin
			r = wpa - ka;
		end else begin
			r = wpa + DEPTH_A - ka;
		end
		return r[PTR_W-1:0];
	endfunction

	logic [WIN_W-1:0] fast_win_q;
	logic [WIN_W-1:0] slow_win_q;
	logic [QTY_W-1:0] order_qty_q;

	logic [WIN_W-1:0] wf;
	logic [WIN_W-1:0] ws;
	logic [WIN_W-1:0] wmax;
	logic [CNT_W-1:0] wmax_p1;
	logic             restart;
	logic             adv;
	logic             accept;

	logic [PTR_W-1:0]      wp_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;
	logic [PRICE_BITS-1:0] price;
	logic [PTR_W-1:0]      raddr_f;
	logic [PTR_W-1:0]      raddr_s;
	logic [PRICE_BITS-1:0] old_f;
	logic [PRICE_BITS-1:0] old_s;

	logic                  v_s1;
	logic [PRICE_BITS-1:0] price_s1;
	logic [QTY_W-1:0]      pos_s1;
	logic                  sub_f_s1;
	logic                  sub_s_s1;
	logic                  warm_s1;

	logic [SUM_W-1:0] fast_sum_q;
	logic [SUM_W-1:0] slow_sum_q;
	logic [SUM_W-1:0] fast_sum_next;
	logic [SUM_W-1:0] slow_sum_next;

	logic             v_s2;
	logic [QTY_W-1:0] pos_s2;
	logic             warm_s2;

	logic              v_s3;
	logic [QTY_W-1:0]  pos_s3;
	logic              warm_s3;
	logic [PROD_W-1:0] prod_f_s3;
	logic [PROD_W-1:0] prod_s_s3;

	cmp_t    now_cmp;
	cmp_t    last_cmp_q;
	signal_t result;
	logic    sig_valid_q;
	signal_t sig_data_q;

	// configuration
	assign cfg.ready = 1'b1;
	assign restart   = cfg.valid && (cfg.data.index == REG_FAST_WINDOW
		|| cfg.data.index == REG_SLOW_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_win_q  <= FAST_WINDOW_RST;
			slow_win_q  <= SLOW_WINDOW_RST;
			order_qty_q <= ORDER_QTY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_FAST_WINDOW: fast_win_q  <= cfg.data.wdata[WIN_W-1:0];
				REG_SLOW_WINDOW: slow_win_q  <= cfg.data.wdata[WIN_W-1:0];
				REG_ORDER_QTY:   order_qty_q <= cfg.data.wdata[QTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign wf      = eff_window(fast_win_q);
	assign ws      = eff_window(slow_win_q);
	assign wmax    = (wf > ws) ? wf : ws;
	assign wmax_p1 = CNT_W'(wmax) + CNT_W'(1);

	// accept stage: write the new price, read both outgoing prices
	assign adv       = !sig_valid_q || sig.ready;
	assign bar.ready = adv;
	assign accept    = bar.valid && adv;

	assign price      = PRICE_BITS'(bar.data.close_price);
	assign raddr_f    = back_addr(wp_q, wf);
	assign raddr_s    = back_addr(wp_q, ws);
	assign count_next = (count_q < wmax_p1) ? count_q + CNT_W'(1) : wmax_p1;

	scs_ram #(
		.WIDTH (PRICE_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(PTR_W)
	) u_price_ring (
		.clk    (clk),
		.we     (accept),
		.waddr  (wp_q),
		.wdata  (price),
		.re     (accept),
		.raddr_a(raddr_f),
		.raddr_b(raddr_s),
		.rdata_a(old_f),
		.rdata_b(old_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			count_q <= '0;
		end else if (restart) begin
			wp_q    <= '0;
			count_q <= '0;
		end else if (accept) begin
			wp_q    <= (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
			count_q <= count_next;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			sig_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			sig_valid_q <= v_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			price_s1 <= price;
			pos_s1   <= bar.data.position_qty;
			sub_f_s1 <= count_q >= CNT_W'(wf);
			sub_s_s1 <= count_q >= CNT_W'(ws);
			warm_s1  <= count_next >= wmax_p1;
		end
		if (adv) begin
			pos_s2     <= pos_s1;
			warm_s2    <= warm_s1;
			pos_s3     <= pos_s2;
			warm_s3    <= warm_s2;
			prod_f_s3  <= PROD_W'(fast_sum_q) * PROD_W'(ws);
			prod_s_s3  <= PROD_W'(slow_sum_q) * PROD_W'(wf);
			sig_data_q <= result;
		end
	end

	// running sums
	assign fast_sum_next = fast_sum_q + SUM_W'(price_s1) - (sub_f_s1 ? SUM_W'(old_f) : '0);
	assign slow_sum_next = slow_sum_q + SUM_W'(price_s1) - (sub_s_s1 ? SUM_W'(old_s) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
		end else if (restart) begin
			fast_sum_q <= '0;
			slow_sum_q <= '0;
		end else if (adv && v_s1) begin
			fast_sum_q <= fast_sum_next;
			slow_sum_q <= slow_sum_next;
		end
	end

	// crossover decision
	always_comb begin
		if (prod_f_s3 > prod_s_s3) begin
			now_cmp = CMP_GT;
		end else if (prod_f_s3 < prod_s_s3) begin
			now_cmp = CMP_LT;
		end else begin
			now_cmp = CMP_EQ;
		end

		result.action    = ACT_NONE;
		result.quantity  = '0;
		result.warmed_up = warm_s3;
		if (warm_s3) begin
			if (last_cmp_q != CMP_GT && now_cmp == CMP_GT && pos_s3 == '0) begin
				result.action   = ACT_BUY;
				result.quantity = order_qty_q;
			end else if (last_cmp_q != CMP_LT && now_cmp == CMP_LT && pos_s3 != '0) begin
				result.action   = ACT_SELL;
				result.quantity = pos_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmp_q <= CMP_EQ;
		end else if (restart) begin
			last_cmp_q <= CMP_EQ;
		end else if (adv && v_s3) begin
			last_cmp_q <= now_cmp;
		end
	end

	assign sig.valid = sig_valid_q;
	assign sig.data  = sig_data_q;

endmodule
